FILE: design/pia_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the positional insert/delete array
package pia_pkg;

  // default array depth
  localparam int CAPACITY = 64;

  // field widths
  localparam int CMD_W  = 3;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int IDX_W  = 6;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;

  // stream data widths, padded to whole bytes
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 48;
  localparam int OUT_PAD_W = M_TDATA_W - (VAL_W + IDX_W + STAT_W + CNT_W);

  // commands
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SHIFT,
    ST_DONE,
    ST_READ
  } state_t;

  // one result from the sequencer to the output register
  typedef struct packed {
    logic              valid;
    logic [VAL_W-1:0]  data;
    logic [IDX_W-1:0]  index;
    status_t           status;
    logic [CNT_W-1:0]  count;
    logic              last;
  } result_t;

endpackage

FILE: design/pia_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram with registered read
module pia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port, read data holds without re
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/pia_seq.sv
`timescale 1ns / 1ps
// command sequencer: decodes commands, walks the entry memory, builds results
module pia_seq #(
  parameter int CAPACITY = pia_pkg::CAPACITY
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [pia_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic                           slot_free,
  output pia_pkg::result_t               res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = pia_pkg::POS_W;
  localparam int VW = pia_pkg::VAL_W;
  localparam int IW = pia_pkg::IDX_W;
  localparam int OW = pia_pkg::CNT_W;
  localparam int XW = (CW > PW) ? CW : PW;

  pia_pkg::state_t  state, state_next;
  pia_pkg::cmd_t    in_cmd, op;
  pia_pkg::status_t chk, res_status;

  logic [PW-1:0] in_pos;
  logic [VW-1:0] in_val;
  logic          accept, full, empty, last_read, ok;
  logic [AW-1:0] ins_pos, pos_q, src, wr_addr, ptr, res_index;
  logic [CW-1:0] count, count_done, left;
  logic          rd_pend;
  logic [VW-1:0] res_data;

  // memory port signals
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [VW-1:0] ram_wdata, ram_rdata;

  pia_ram #(
    .WIDTH(VW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // input fields
  assign in_cmd = pia_pkg::cmd_t'(s_tdata[pia_pkg::CMD_W-1:0]);
  assign in_pos = s_tdata[pia_pkg::CMD_W +: PW];
  assign in_val = s_tdata[pia_pkg::CMD_W + PW +: VW];
  assign accept = s_tvalid && s_tready;

  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);
  assign last_read = (CW'(ptr) == count - CW'(1));
  // append is an insert at the current end
  assign ins_pos   = (in_cmd == pia_pkg::CMD_APPEND) ? AW'(count) : AW'(in_pos);

  // status check of the incoming command
  always_comb begin
    chk = pia_pkg::STAT_OK;
    unique case (in_cmd)
      pia_pkg::CMD_APPEND: begin
        if (full) chk = pia_pkg::STAT_FULL;
      end
      pia_pkg::CMD_INSERT: begin
        if (full) chk = pia_pkg::STAT_FULL;
        else if (XW'(in_pos) > XW'(count)) chk = pia_pkg::STAT_RANGE;
      end
      pia_pkg::CMD_DELETE: begin
        if (empty) chk = pia_pkg::STAT_EMPTY;
        else if (XW'(in_pos) >= XW'(count)) chk = pia_pkg::STAT_RANGE;
      end
      pia_pkg::CMD_READ: begin
        if (empty) chk = pia_pkg::STAT_EMPTY;
      end
      default: chk = pia_pkg::STAT_OK;
    endcase
  end

  // fill count after a finished command
  always_comb begin
    count_done = count;
    if (op == pia_pkg::CMD_CLEAR) count_done = '0;
    else if (ok && op == pia_pkg::CMD_INSERT) count_done = count + CW'(1);
    else if (ok && op == pia_pkg::CMD_DELETE) count_done = count - CW'(1);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pia_pkg::ST_IDLE: begin
        if (accept) begin
          if (chk != pia_pkg::STAT_OK) begin
            state_next = pia_pkg::ST_DONE;
          end else begin
            unique case (in_cmd)
              pia_pkg::CMD_CLEAR:  state_next = pia_pkg::ST_DONE;
              pia_pkg::CMD_APPEND: state_next = pia_pkg::ST_SHIFT;
              pia_pkg::CMD_INSERT: state_next = pia_pkg::ST_SHIFT;
              pia_pkg::CMD_DELETE: state_next = pia_pkg::ST_LOAD;
              pia_pkg::CMD_READ:   state_next = pia_pkg::ST_READ;
              default:             state_next = pia_pkg::ST_IDLE;
            endcase
          end
        end
      end
      pia_pkg::ST_LOAD:  state_next = pia_pkg::ST_SHIFT;
      pia_pkg::ST_SHIFT: begin
        if (left == '0) state_next = pia_pkg::ST_DONE;
      end
      pia_pkg::ST_DONE: begin
        if (slot_free) state_next = pia_pkg::ST_IDLE;
      end
      pia_pkg::ST_READ: begin
        if (slot_free && last_read) state_next = pia_pkg::ST_IDLE;
      end
      default: state_next = pia_pkg::ST_IDLE;
    endcase
  end

  // memory controls, input ready and result
  always_comb begin
    s_tready   = (state == pia_pkg::ST_IDLE);
    ram_re     = 1'b0;
    ram_raddr  = src;
    ram_we     = 1'b0;
    ram_waddr  = wr_addr;
    ram_wdata  = ram_rdata;
    res.valid  = 1'b0;
    res.data   = res_data;
    res.index  = IW'(res_index);
    res.status = res_status;
    res.count  = OW'(count_done);
    res.last   = 1'b1;
    unique case (state)
      pia_pkg::ST_IDLE: begin
        // delete fetches the removed entry, read-all fetches entry zero
        ram_re    = accept;
        ram_raddr = (in_cmd == pia_pkg::CMD_READ) ? '0 : AW'(in_pos);
      end
      pia_pkg::ST_LOAD: begin
        ram_re = 1'b0;
      end
      pia_pkg::ST_SHIFT: begin
        // write back the entry read last cycle, read the next one
        ram_we = rd_pend;
        ram_re = (left != '0);
      end
      pia_pkg::ST_DONE: begin
        if (slot_free) begin
          res.valid = 1'b1;
          if (ok && op == pia_pkg::CMD_INSERT) begin
            ram_we    = 1'b1;
            ram_waddr = pos_q;
            ram_wdata = res_data;
          end
        end
      end
      pia_pkg::ST_READ: begin
        res.data   = ram_rdata;
        res.index  = IW'(ptr);
        res.status = pia_pkg::STAT_OK;
        res.count  = OW'(count);
        res.last   = last_read;
        if (slot_free) begin
          res.valid = 1'b1;
          if (!last_read) begin
            ram_re    = 1'b1;
            ram_raddr = ptr + AW'(1);
          end
        end
      end
      default: ram_re = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= pia_pkg::ST_IDLE;
      count   <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == pia_pkg::ST_SHIFT) && (left != '0);
      if (state == pia_pkg::ST_DONE && slot_free) begin
        count <= count_done;
      end
    end
  end

  // command payload and walk pointers
  always_ff @(posedge clk) begin
    unique case (state)
      pia_pkg::ST_IDLE: begin
        if (accept) begin
          op         <= (in_cmd == pia_pkg::CMD_APPEND) ? pia_pkg::CMD_INSERT : in_cmd;
          ok         <= (chk == pia_pkg::STAT_OK);
          res_status <= chk;
          pos_q      <= ins_pos;
          ptr        <= '0;
          res_data   <= '0;
          res_index  <= '0;
          if (chk == pia_pkg::STAT_OK) begin
            if (in_cmd == pia_pkg::CMD_APPEND || in_cmd == pia_pkg::CMD_INSERT) begin
              res_data  <= in_val;
              res_index <= ins_pos;
            end else if (in_cmd == pia_pkg::CMD_DELETE) begin
              res_index <= ins_pos;
            end
          end
          if (in_cmd == pia_pkg::CMD_DELETE) begin
            left <= count - CW'(in_pos) - CW'(1);
            src  <= AW'(in_pos) + AW'(1);
          end else begin
            left <= count - CW'(ins_pos);
            src  <= AW'(count - CW'(1));
          end
        end
      end
      pia_pkg::ST_LOAD: begin
        res_data <= ram_rdata;
      end
      pia_pkg::ST_SHIFT: begin
        if (left != '0) begin
          left <= left - CW'(1);
          if (op == pia_pkg::CMD_INSERT) begin
            wr_addr <= src + AW'(1);
            src     <= src - AW'(1);
          end else begin
            wr_addr <= src - AW'(1);
            src     <= src + AW'(1);
          end
        end
      end
      pia_pkg::ST_READ: begin
        if (slot_free && !last_read) begin
          ptr <= ptr + AW'(1);
        end
      end
      default: ptr <= ptr;
    endcase
  end

endmodule

FILE: design/positional_insert_delete_array.sv
`timescale 1ns / 1ps
// Positional insert/delete array, top level with output register stage.
// Clear and rejected commands go from idle straight to the done state; append and insert
// pass through the shift state and delete through load and shift, one memory move per cycle;
// read-all presents the entries in order, one per cycle while the output register is free.
// One command at a time: the next transfer is taken once the last result is built.
// Synchronous reset empties the array (fill count 0); the entry memory is not cleared.
module positional_insert_delete_array #(
  parameter int CAPACITY = pia_pkg::CAPACITY
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // cmd [2:0], position [9:3], value [41:10], zero fill above
  input  logic [pia_pkg::S_TDATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // data [31:0], index [37:32], status [39:38], count [46:40], zero fill above
  output logic [pia_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic                           m_tlast
);

  pia_pkg::result_t res;
  logic             slot_free;

  // output register can take a result when empty or being drained
  assign slot_free = !m_tvalid || m_tready;

  pia_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .slot_free(slot_free),
    .res      (res)
  );

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (slot_free) begin
      m_tvalid <= res.valid;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (slot_free && res.valid) begin
      m_tdata <= {{pia_pkg::OUT_PAD_W{1'b0}}, res.count, res.status, res.index, res.data};
      m_tlast <= res.last;
    end
  end

endmodule

FILE: design/pia_checker.sv
`timescale 1ns / 1ps
// port checker for the positional insert/delete array, with its bind
module pia_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [pia_pkg::S_TDATA_W-1:0]  s_tdata,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [pia_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic                           m_tlast
);

  // no result straight after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // a known command blocks the input until its work is done
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tdata[2:0] <= pia_pkg::CMD_READ) |=> !s_tready)
    else $error("input taken while a command is in progress");

  // a rejected command gives a single result with zero data and index
  a_reject: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[39:38] != pia_pkg::STAT_OK) |-> m_tlast && (m_tdata[37:0] == '0))
    else $error("rejected command result malformed");

  // an empty report carries a zero count
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[39:38] == pia_pkg::STAT_EMPTY) |-> (m_tdata[46:40] == '0))
    else $error("empty status with non-zero count");

endmodule

bind positional_insert_delete_array pia_checker u_pia_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tdata (s_tdata),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);

FILE: sim/positional_insert_delete_array_tb.sv
`timescale 1ns / 1ps
// self-checking stream testbench for the positional insert/delete array
module positional_insert_delete_array_tb;
  import pia_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int RESET_HOLD  = 8;
  localparam int ITEM_TARGET = 370;
  localparam int TAIL_ITEMS  = 40;
  localparam int HOLD_AT     = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 100;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int PRINT_LIMIT = 100;

  // command codes the block has no use for
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
  localparam logic [CMD_W-1:0] CMD_LAST_UNUSED  = 3'd7;

  typedef struct {
    logic [CMD_W-1:0] op;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
  } array_command_t;

  typedef struct {
    logic [VAL_W-1:0] data;
    logic [IDX_W-1:0] index;
    status_t          status;
    logic [CNT_W-1:0] count;
    logic             last;
  } array_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;

  // stimulus and expectation stores
  array_command_t pending_commands[$];
  array_result_t  due_results[$];

  // mirror of the array contents
  logic [VAL_W-1:0] shadow_entries[CAPACITY];
  int               shadow_fill = 0;

  // fill level as the stimulus plan sees it
  int plan_fill     = 0;
  int planned_items = 0;

  array_command_t offer;
  array_result_t  got_result;
  array_result_t  want_result;
  int  sent_count    = 0;
  int  result_count  = 0;
  int  error_count   = 0;
  int  send_gap_left = 0;
  int  recv_gap_left = 0;
  int  hold_left     = 0;
  int  hold_seen     = 0;
  int  send_gap_pct  = 20;
  int  recv_gap_pct  = 20;
  int  cycle_count   = 0;
  logic calm_tail    = 1'b0;

  positional_insert_delete_array u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // idle density for the next stretch: none, light or heavy
  function automatic int pick_gap_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 45;
    endcase
  endfunction

  // mostly uniform values, sometimes the signed extremes, zero or minus one
  function automatic logic [VAL_W-1:0] random_value();
    if ($urandom_range(0, 7) != 0) return $urandom();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // append a command to the plan and track the fill level it leads to
  task automatic queue_command(input logic [CMD_W-1:0] op, input int pos,
                               input logic [VAL_W-1:0] val);
    array_command_t c;
    c.op       = op;
    c.position = pos[POS_W-1:0];
    c.value    = val;
    pending_commands.push_back(c);
    case (op)
      CMD_CLEAR:  plan_fill = 0;
      CMD_APPEND: if (plan_fill < CAPACITY) plan_fill++;
      CMD_INSERT: if (plan_fill < CAPACITY && pos <= plan_fill) plan_fill++;
      CMD_DELETE: if (plan_fill > 0 && pos < plan_fill) plan_fill--;
      default: ;
    endcase
    if (op <= CMD_READ) planned_items++;
  endtask

  // apply one accepted command to the mirror and queue the results it gives
  task automatic update_shadow_array(input array_command_t c);
    array_result_t r;
    int k;
    r.data   = '0;
    r.index  = '0;
    r.status = STAT_OK;
    r.last   = 1'b1;
    case (c.op)
      CMD_CLEAR: shadow_fill = 0;
      CMD_APPEND: begin
        if (shadow_fill >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          shadow_entries[shadow_fill] = c.value;
          r.data  = c.value;
          r.index = shadow_fill[IDX_W-1:0];
          shadow_fill++;
        end
      end
      CMD_INSERT: begin
        if (shadow_fill >= CAPACITY) begin
          r.status = STAT_FULL;
        end else if (c.position > shadow_fill) begin
          r.status = STAT_RANGE;
        end else begin
          for (k = shadow_fill; k > c.position; k--)
            shadow_entries[k] = shadow_entries[k-1];
          shadow_entries[c.position] = c.value;
          r.data  = c.value;
          r.index = c.position[IDX_W-1:0];
          shadow_fill++;
        end
      end
      CMD_DELETE: begin
        if (shadow_fill == 0) begin
          r.status = STAT_EMPTY;
        end else if (c.position >= shadow_fill) begin
          r.status = STAT_RANGE;
        end else begin
          r.data  = shadow_entries[c.position];
          r.index = c.position[IDX_W-1:0];
          for (k = c.position; k + 1 < shadow_fill; k++)
            shadow_entries[k] = shadow_entries[k+1];
          shadow_fill--;
        end
      end
      CMD_READ: begin
        if (shadow_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          // one result per stored entry, last flag on the final one
          for (k = 0; k < shadow_fill; k++) begin
            r.data  = shadow_entries[k];
            r.index = k[IDX_W-1:0];
            r.count = shadow_fill[CNT_W-1:0];
            r.last  = (k + 1 == shadow_fill);
            due_results.push_back(r);
          end
          return;
        end
      end
      default: return;
    endcase
    r.count = shadow_fill[CNT_W-1:0];
    due_results.push_back(r);
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < PRINT_LIMIT)
      $display("mismatch: %s on result %0d, got %0h, want %0h",
               field, result_count, got, want);
    error_count++;
  endtask

  // stimulus plan, then wait for the block to drain
  initial begin
    int  roll;
    bit  grow;
    grow = 1'b1;

    // directed: empty-array cases, range edges, extremes, ignored codes
    queue_command(CMD_READ, 0, '0);
    queue_command(CMD_DELETE, 0, '0);
    queue_command(CMD_INSERT, 1, 32'h1111_1111);
    queue_command(CMD_INSERT, 0, 32'h8000_0000);
    queue_command(CMD_APPEND, 0, 32'h7fff_ffff);
    queue_command(CMD_INSERT, 2, 32'h0000_0000);
    queue_command(CMD_INSERT, 1, 32'hffff_ffff);
    queue_command(CMD_APPEND, 0, 32'h1234_5678);
    queue_command(CMD_DELETE, 5, '0);
    queue_command(CMD_DELETE, 127, '0);
    queue_command(CMD_INSERT, 127, 32'h5555_5555);
    queue_command(CMD_INSERT, 64, 32'haaaa_aaaa);
    queue_command(CMD_READ, 0, '0);
    queue_command(CMD_DELETE, 0, '0);
    queue_command(CMD_DELETE, 3, '0);
    queue_command(CMD_READ, 0, '0);
    for (int u = CMD_FIRST_UNUSED; u <= CMD_LAST_UNUSED; u++)
      queue_command(u[CMD_W-1:0], 127, 32'hffff_ffff);
    queue_command(CMD_CLEAR, 0, '0);
    queue_command(CMD_READ, 0, '0);
    queue_command(CMD_APPEND, 0, 32'hffff_ffff);
    queue_command(CMD_DELETE, 0, '0);
    queue_command(CMD_CLEAR, 0, '0);

    // well-formed climb to a full array, then the full and top-entry cases
    while (plan_fill < CAPACITY) begin
      if ($urandom_range(0, 1))
        queue_command(CMD_APPEND, 0, random_value());
      else
        queue_command(CMD_INSERT, $urandom_range(0, plan_fill), random_value());
    end
    queue_command(CMD_APPEND, 0, random_value());
    queue_command(CMD_INSERT, $urandom_range(0, CAPACITY), random_value());
    queue_command(CMD_READ, 0, '0);
    queue_command(CMD_DELETE, CAPACITY - 1, '0);
    queue_command(CMD_INSERT, CAPACITY - 1, random_value());
    queue_command(CMD_DELETE, CAPACITY, '0);
    queue_command(CMD_DELETE, 0, '0);

    // random part: grow and shrink phases with some noise mixed in
    while (planned_items < ITEM_TARGET) begin
      if (plan_fill == CAPACITY) grow = 1'b0;
      else if (plan_fill == 0) grow = 1'b1;
      else if ($urandom_range(0, 39) == 0) grow = !grow;
      roll = $urandom_range(0, 99);
      if (roll < 3)
        queue_command(CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED)),
                      $urandom_range(0, 127), random_value());
      else if (roll < 7)
        queue_command($urandom_range(0, 1) ? CMD_INSERT : CMD_DELETE,
                      $urandom_range(0, 127), random_value());
      else if (roll < 9 && !grow)
        queue_command(CMD_CLEAR, $urandom_range(0, 127), random_value());
      else if (roll < 17)
        queue_command(CMD_READ, $urandom_range(0, 127), random_value());
      else if ((roll < 75) == grow) begin
        if ($urandom_range(0, 2) == 0)
          queue_command(CMD_APPEND, $urandom_range(0, 127), random_value());
        else
          queue_command(CMD_INSERT, $urandom_range(0, plan_fill), random_value());
      end else
        queue_command(CMD_DELETE, $urandom_range(0, plan_fill > 0 ? plan_fill - 1 : 0),
                      random_value());
    end

    repeat (RESET_HOLD) @(posedge clk);
    rst <= 1'b0;

    while (pending_commands.size() > 0 || s_tvalid) @(posedge clk);
    while (due_results.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // sender: offers planned commands, predicts on each transfer
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        update_shadow_array(offer);
        sent_count++;
        if (sent_count % 32 == 0) send_gap_pct = pick_gap_pct();
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap_left == 0 && !calm_tail && $urandom_range(0, 99) < send_gap_pct)
          send_gap_left = $urandom_range(1, 9);
        if (send_gap_left > 0) begin
          send_gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_commands.size() > 0) begin
          offer = pending_commands.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {{(S_TDATA_W - CMD_W - POS_W - VAL_W){1'b0}},
                       offer.value, offer.position, offer.op};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      calm_tail <= (pending_commands.size() < TAIL_ITEMS);
    end
  end

  // one long hold-off after some result transfers so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_seen <= 0;
    end else begin
      if (m_tvalid && m_tready) hold_seen <= hold_seen + 1;
      if (hold_left > 0)
        hold_left <= hold_left - 1;
      else if (m_tvalid && m_tready && hold_seen == HOLD_AT - 1)
        hold_left <= HOLD_CYCLES;
    end
  end

  // receiver: checks each result transfer and paces m_tready
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_result.data   = m_tdata[VAL_W-1:0];
        got_result.index  = m_tdata[VAL_W +: IDX_W];
        got_result.status = status_t'(m_tdata[VAL_W + IDX_W +: STAT_W]);
        got_result.count  = m_tdata[VAL_W + IDX_W + STAT_W +: CNT_W];
        got_result.last  = m_tlast;
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result", {m_tlast, m_tdata}, '0);
        end else begin
          want_result = due_results.pop_front();
          if (got_result.data !== want_result.data)
            report_mismatch("data", got_result.data, want_result.data);
          if (got_result.index !== want_result.index)
            report_mismatch("index", got_result.index, want_result.index);
          if (got_result.status !== want_result.status)
            report_mismatch("status", got_result.status, want_result.status);
          if (got_result.count !== want_result.count)
            report_mismatch("count", got_result.count, want_result.count);
          if (got_result.last !== want_result.last)
            report_mismatch("last", got_result.last, want_result.last);
        end
        result_count++;
        if (result_count % 32 == 0) recv_gap_pct = pick_gap_pct();
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
      end else if (recv_gap_left > 0) begin
        recv_gap_left--;
        m_tready <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 99) < recv_gap_pct) begin
        recv_gap_left = $urandom_range(1, 9) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

FILE: positional_insert_delete_array.f
design/pia_pkg.sv
design/pia_ram.sv
design/pia_seq.sv
design/positional_insert_delete_array.sv
design/pia_checker.sv
sim/positional_insert_delete_array_tb.sv
